>>> rtl/opwl_pkg.sv
// opwl_pkg: shared widths, codes, register defaults and structs of the
// oil pressure warning lamp core; no dependencies
`default_nettype none

package opwl_pkg;

  // tick counters
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SLOW_PHASE_END = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_PHASE_END = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_OFF_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ON_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_OFF_TICKS = 3'd5;

  localparam logic [CFG_W-1:0] DEF_SLOW_PHASE_END = 16'd10000;
  localparam logic [CFG_W-1:0] DEF_FAST_PHASE_END = 16'd15000;
  localparam logic [CFG_W-1:0] DEF_SLOW_ON_TICKS  = 16'd100;
  localparam logic [CFG_W-1:0] DEF_SLOW_OFF_TICKS = 16'd900;
  localparam logic [CFG_W-1:0] DEF_FAST_ON_TICKS  = 16'd30;
  localparam logic [CFG_W-1:0] DEF_FAST_OFF_TICKS = 16'd270;

  // result mode codes
  localparam int MODE_W = 3;
  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_OK       = 3'd0;
  localparam mode_t MODE_SLOW     = 3'd1;
  localparam mode_t MODE_FAST     = 3'd2;
  localparam mode_t MODE_TIMEOUT  = 3'd3;
  localparam mode_t MODE_LOST     = 3'd4;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic [CFG_W-1:0] slow_phase_end;
    logic [CFG_W-1:0] fast_phase_end;
    logic [CFG_W-1:0] slow_on_ticks;
    logic [CFG_W-1:0] slow_off_ticks;
    logic [CFG_W-1:0] fast_on_ticks;
    logic [CFG_W-1:0] fast_off_ticks;
  } opwl_cfg_t;

  typedef struct packed {
    count_t elapsed;
    count_t since_toggle;
    logic   blink_level;
    logic   seen_ok;
  } opwl_state_t;

endpackage

`default_nettype wire

>>> rtl/opwl_ifs.sv
// opwl_ifs: valid/ready channel interfaces of the oil pressure warning lamp
// core (tick input, lamp result, register write); depends on opwl_pkg
`default_nettype none

interface opwl_in_if;
  logic valid;
  logic ready;
  logic pressure_ok;

  modport source (output valid, output pressure_ok, input ready);
  modport sink   (input valid, input pressure_ok, output ready);
endinterface

interface opwl_out_if import opwl_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  lamp;
  mode_t mode;

  modport source (output valid, output lamp, output mode, input ready);
  modport sink   (input valid, input lamp, input mode, output ready);
endinterface

interface opwl_cfg_if import opwl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/opwl_cfg_regs.sv
// opwl_cfg_regs: the six timing registers behind the write channel
// depends on opwl_pkg and opwl_ifs
`default_nettype none

module opwl_cfg_regs import opwl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  opwl_cfg_if.sink   wr,
  output opwl_cfg_t  regs
);

  opwl_cfg_t regs_r;
  opwl_cfg_t regs_nxt;

  assign wr.ready = 1'b1;
  assign regs     = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr.valid) begin
      unique case (wr.reg_index)
        REG_SLOW_PHASE_END: regs_nxt.slow_phase_end = wr.wdata;
        REG_FAST_PHASE_END: regs_nxt.fast_phase_end = wr.wdata;
        REG_SLOW_ON_TICKS:  regs_nxt.slow_on_ticks  = wr.wdata;
        REG_SLOW_OFF_TICKS: regs_nxt.slow_off_ticks = wr.wdata;
        REG_FAST_ON_TICKS:  regs_nxt.fast_on_ticks  = wr.wdata;
        REG_FAST_OFF_TICKS: regs_nxt.fast_off_ticks = wr.wdata;
        default:            regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.slow_phase_end <= DEF_SLOW_PHASE_END;
      regs_r.fast_phase_end <= DEF_FAST_PHASE_END;
      regs_r.slow_on_ticks  <= DEF_SLOW_ON_TICKS;
      regs_r.slow_off_ticks <= DEF_SLOW_OFF_TICKS;
      regs_r.fast_on_ticks  <= DEF_FAST_ON_TICKS;
      regs_r.fast_off_ticks <= DEF_FAST_OFF_TICKS;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/opwl_step.sv
// opwl_step: lamp decision and next counter/latch state for one tick
// depends on opwl_pkg
`default_nettype none

module opwl_step import opwl_pkg::*; (
  input  wire logic  pressure_ok,
  input  opwl_state_t cur,
  input  opwl_cfg_t   regs,
  output opwl_state_t nxt,
  output logic        lamp,
  output mode_t       mode
);

  logic             in_slow;
  logic             in_fast;
  logic [CFG_W-1:0] on_t;
  logic [CFG_W-1:0] off_t;
  logic [CFG_W-1:0] interval;
  logic             toggle;
  logic             new_blink;

  assign in_slow  = CMP_W'(cur.elapsed) < CMP_W'(regs.slow_phase_end);
  assign in_fast  = CMP_W'(cur.elapsed) < CMP_W'(regs.fast_phase_end);
  assign on_t     = in_slow ? regs.slow_on_ticks  : regs.fast_on_ticks;
  assign off_t    = in_slow ? regs.slow_off_ticks : regs.fast_off_ticks;
  assign interval = cur.blink_level ? on_t : off_t;

  always_comb begin
    toggle    = 1'b0;
    new_blink = cur.blink_level;
    nxt.seen_ok = cur.seen_ok;
    priority if (pressure_ok) begin
      nxt.seen_ok = 1'b1;
      lamp        = 1'b0;
      mode        = MODE_OK;
    end else if (cur.seen_ok) begin
      lamp = 1'b1;
      mode = MODE_LOST;
    end else if (in_slow || in_fast) begin
      toggle    = CMP_W'(cur.since_toggle) >= CMP_W'(interval);
      new_blink = cur.blink_level ^ toggle;
      lamp      = new_blink;
      mode      = in_slow ? MODE_SLOW : MODE_FAST;
    end else begin
      lamp = 1'b1;
      mode = MODE_TIMEOUT;
    end
    nxt.blink_level = new_blink;

    // saturating counters
    if (toggle) begin
      nxt.since_toggle = count_t'(1);
    end else if (cur.since_toggle == COUNT_MAX) begin
      nxt.since_toggle = COUNT_MAX;
    end else begin
      nxt.since_toggle = cur.since_toggle + count_t'(1);
    end
    if (cur.elapsed == COUNT_MAX) begin
      nxt.elapsed = COUNT_MAX;
    end else begin
      nxt.elapsed = cur.elapsed + count_t'(1);
    end
  end

endmodule

`default_nettype wire

>>> rtl/oil_pressure_warning_lamp_core.sv
// oil_pressure_warning_lamp_core: top level of the oil pressure warning lamp
// depends on opwl_pkg, opwl_ifs, opwl_cfg_regs and opwl_step
`default_nettype none

// Each input word is one millisecond tick with the pressure switch level and
// yields exactly one result word (lamp drive and mode). The block takes one
// tick per clock while the result side does not stall: a tick goes into an
// input register, then the lamp decision and the counter/latch update are made
// in one pass of compare and increment logic and land in the output register.
// Both stages hold while the result side stalls; input ready drops only
// when both registers are full. Register writes are always accepted and
// should only be made while no tick is in flight. Counters are 16 bits wide
// and saturate instead of wrapping.
module oil_pressure_warning_lamp_core import opwl_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  opwl_in_if.sink      in_ch,
  opwl_out_if.source   out_ch,
  opwl_cfg_if.sink     cfg_ch
);

  opwl_cfg_t   regs;

  // input register
  logic        s1_valid_r;
  logic        s1_ok_r;

  // tick state
  opwl_state_t st_r;
  opwl_state_t st_nxt;

  // result register
  logic        out_valid_r;
  logic        out_lamp_r;
  mode_t       out_mode_r;

  logic        step_lamp;
  mode_t       step_mode;
  logic        res_free;
  logic        s1_fire;
  logic        in_fire;

  opwl_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (cfg_ch),
    .regs  (regs)
  );

  opwl_step u_step (
    .pressure_ok (s1_ok_r),
    .cur         (st_r),
    .regs        (regs),
    .nxt         (st_nxt),
    .lamp        (step_lamp),
    .mode        (step_mode)
  );

  // result slot is free if empty or being taken this cycle
  assign res_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && res_free;
  assign in_ch.ready  = !s1_valid_r || res_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.lamp  = out_lamp_r;
  assign out_ch.mode  = out_mode_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      st_r.elapsed     <= '0;
      st_r.since_toggle <= '0;
      st_r.blink_level <= 1'b0;
      st_r.seen_ok     <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok_r <= in_ch.pressure_ok;
    end
    if (s1_fire) begin
      out_lamp_r <= step_lamp;
      out_mode_r <= step_mode;
    end
  end

`ifndef SYNTHESIS
  // once pressure was seen the latch never clears
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.seen_ok |=> st_r.seen_ok)
    else $error("seen_ok latch cleared");

  // a blink or timeout result can only exist before the latch is set
  a_blink_before_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_mode_r == MODE_SLOW || out_mode_r == MODE_FAST ||
                    out_mode_r == MODE_TIMEOUT) |-> !st_r.seen_ok)
    else $error("blink result with latch set");

  // pressure ok result always has the lamp dark, lost and timeout have it lit
  a_lamp_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_mode_r == MODE_OK) ? !out_lamp_r :
                     ((out_mode_r == MODE_LOST || out_mode_r == MODE_TIMEOUT)
                      ? out_lamp_r : 1'b1)))
    else $error("lamp level does not match mode");

  // elapsed count advances by one per processed tick until it saturates
  a_elapsed_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (st_r.elapsed != COUNT_MAX) |=>
      st_r.elapsed == $past(st_r.elapsed) + count_t'(1))
    else $error("elapsed count did not advance");

  // state only moves when a tick is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(st_r))
    else $error("state changed without a tick");
`endif

endmodule

`default_nettype wire
